// File: sv/i2c_framed_master_core_assert.svh
// Assertion macros for the framed I2C master core
`ifndef I2C_FRAMED_MASTER_CORE_ASSERT_SVH
`define I2C_FRAMED_MASTER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IFM_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define IFM_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define IFM_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define IFM_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

// File: sv/ifm_pkg.sv
// Package: types and constants for the framed I2C master core
package ifm_pkg;
    localparam int unsigned TICKS_PER_US = 1;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_WR_NACK = 2'd1;
    localparam logic [1:0] ST_RETRY   = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    localparam logic [1:0] KIND_LEN    = 2'd0;
    localparam logic [1:0] KIND_PAY    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] REG_WR_ADDR = 2'd0;
    localparam logic [1:0] REG_RD_ADDR = 2'd1;
    localparam logic [1:0] REG_RETRY   = 2'd2;
    localparam logic [1:0] REG_STRETCH = 2'd3;

    typedef enum logic [4:0] {
        P_IDLE, P_START_A, P_START_B, P_TX_LOW, P_TX_DATA, P_TX_HIGH,
        P_CA_LOW, P_CA_HIGH, P_WR_GAP, P_SP_A, P_SP_B, P_SP_C, P_RT_GAP,
        P_RX_LOW, P_RX_STRETCH, P_RX_HOLD, P_AK_A, P_AK_B, P_NK_A, P_NK_B
    } t_phase;

    typedef struct packed {
        logic [7:0]  wr_addr;
        logic [7:0]  rd_addr;
        logic [20:0] retry_limit;
        logic [7:0]  stretch_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic       first;
        logic       last;
        logic       sda;
        logic       scl;
    } t_item;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [1:0] rx_kind;
        logic       rx_last;
        logic       done;
        logic [1:0] status;
    } t_result;

    function automatic logic [15:0] us_ticks(input logic [2:0] us);
        return 16'(32'(us) * TICKS_PER_US);
    endfunction
endpackage

// File: sv/ifm_cfg_regs.sv
// Configuration register file
module ifm_cfg_regs
    import ifm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data,
    output t_cfg        o_cfg
);
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wr_addr       <= 8'h50;
            r_cfg.rd_addr       <= 8'h51;
            r_cfg.retry_limit   <= 21'd1500000;
            r_cfg.stretch_limit <= 8'd30;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WR_ADDR: r_cfg.wr_addr <= i_cfg_data[7:0];
                REG_RD_ADDR: r_cfg.rd_addr <= i_cfg_data[7:0];
                REG_RETRY:   r_cfg.retry_limit <= i_cfg_data;
                REG_STRETCH: r_cfg.stretch_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// File: sv/ifm_engine.sv
// Bus sequencer: one item in, one result out per cycle while i_step is high
module ifm_engine
    import ifm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_res
);
    t_phase r_phase, n_phase;
    logic [15:0] r_delay, n_delay;
    logic [3:0]  r_bits, n_bits;
    logic [7:0]  r_shift, n_shift;
    logic [20:0] r_retry, n_retry;
    logic [7:0]  r_stretch, n_stretch;
    logic [15:0] r_flen, n_flen;
    logic [15:0] r_left, n_left;
    logic        r_scl, n_scl, r_sda, n_sda;
    logic        r_rd, n_rd, r_addr, n_addr, r_hlast, n_hlast;
    logic [7:0]  r_hbyte, n_hbyte;
    logic [1:0]  r_est, n_est, r_stage, n_stage;
    t_result     n_res;
    logic [15:0] v_left, v_flen, v_pay;
    logic [7:0]  v_sh;
    logic        v_last;

    always_comb begin
        n_phase = r_phase; n_delay = r_delay; n_bits = r_bits; n_shift = r_shift;
        n_retry = r_retry; n_stretch = r_stretch; n_flen = r_flen; n_left = r_left;
        n_scl = r_scl; n_sda = r_sda; n_rd = r_rd; n_addr = r_addr;
        n_hlast = r_hlast; n_hbyte = r_hbyte; n_est = r_est; n_stage = r_stage;
        n_res = '0;
        v_left = '0; v_flen = '0; v_pay = '0; v_sh = '0; v_last = 1'b0;
        if (i_item.op == OP_TICK) begin
            if (r_phase != P_IDLE) begin
                if (r_delay > 16'd1) begin
                    n_delay = r_delay - 16'd1;
                end else begin
                    n_delay = '0;
                    case (r_phase)
                        P_START_A: begin
                            n_sda = 1'b0; n_phase = P_START_B; n_delay = us_ticks(3'd4);
                        end
                        P_START_B: begin
                            n_shift = r_rd ? i_cfg.rd_addr : i_cfg.wr_addr;
                            n_bits = '0; n_scl = 1'b0;
                            n_phase = P_TX_LOW; n_delay = us_ticks(3'd2);
                        end
                        P_TX_LOW: begin
                            n_sda = r_shift[7]; n_phase = P_TX_DATA; n_delay = us_ticks(3'd1);
                        end
                        P_TX_DATA: begin
                            n_scl = 1'b1; n_phase = P_TX_HIGH; n_delay = us_ticks(3'd2);
                        end
                        P_TX_HIGH: begin
                            n_shift = {r_shift[6:0], 1'b0};
                            n_bits = r_bits + 4'd1;
                            n_scl = 1'b0;
                            if (r_bits < 4'd7) begin
                                n_phase = P_TX_LOW; n_delay = us_ticks(3'd2);
                            end else begin
                                n_sda = 1'b1; n_phase = P_CA_LOW; n_delay = us_ticks(3'd4);
                            end
                        end
                        P_CA_LOW: begin
                            n_scl = 1'b1; n_phase = P_CA_HIGH; n_delay = us_ticks(3'd4);
                        end
                        P_CA_HIGH: begin
                            if (r_rd) begin
                                if (i_item.sda) begin
                                    n_est = ST_RETRY; n_scl = 1'b0;
                                    n_phase = P_SP_A; n_delay = us_ticks(3'd1);
                                end else begin
                                    n_addr = 1'b0; n_stage = KIND_LEN; n_left = 16'd2;
                                    n_shift = '0; n_bits = '0; n_stretch = '0; n_scl = 1'b0;
                                    n_phase = P_RX_LOW; n_delay = us_ticks(3'd4);
                                end
                            end else if (i_item.sda) begin
                                n_est = ST_WR_NACK; n_scl = 1'b0;
                                n_phase = P_SP_A; n_delay = us_ticks(3'd1);
                            end else if (r_addr) begin
                                n_addr = 1'b0; n_phase = P_WR_GAP; n_delay = us_ticks(3'd1);
                            end else if (r_hlast) begin
                                n_est = ST_OK; n_scl = 1'b0;
                                n_phase = P_SP_A; n_delay = us_ticks(3'd1);
                            end else begin
                                n_phase = P_IDLE; n_res.done = 1'b1; n_res.status = ST_OK;
                            end
                        end
                        P_WR_GAP: begin
                            n_shift = r_hbyte; n_bits = '0; n_scl = 1'b0;
                            n_phase = P_TX_LOW; n_delay = us_ticks(3'd2);
                        end
                        P_SP_A: begin
                            n_sda = 1'b0; n_phase = P_SP_B; n_delay = us_ticks(3'd3);
                        end
                        P_SP_B: begin
                            n_scl = 1'b1; n_phase = P_SP_C; n_delay = us_ticks(3'd3);
                        end
                        P_SP_C: begin
                            n_sda = 1'b1;
                            if (r_rd && r_addr) begin
                                if (r_retry == i_cfg.retry_limit) begin
                                    n_phase = P_IDLE; n_res.done = 1'b1;
                                    n_res.status = ST_RETRY;
                                end else begin
                                    n_retry = r_retry + 21'd1;
                                    n_phase = P_RT_GAP; n_delay = us_ticks(3'd1);
                                end
                            end else begin
                                n_phase = P_IDLE; n_res.done = 1'b1; n_res.status = r_est;
                            end
                        end
                        P_RT_GAP: begin
                            n_sda = 1'b1; n_scl = 1'b1;
                            n_phase = P_START_A; n_delay = us_ticks(3'd2);
                        end
                        P_RX_LOW, P_RX_STRETCH: begin
                            if (r_phase == P_RX_LOW) n_scl = 1'b1;
                            if (i_item.scl) begin
                                n_phase = P_RX_HOLD; n_delay = us_ticks(3'd4);
                            end else if (r_stretch > i_cfg.stretch_limit) begin
                                n_est = ST_TIMEOUT; n_scl = 1'b0;
                                n_phase = P_SP_A; n_delay = us_ticks(3'd1);
                            end else begin
                                if (r_stretch != 8'hFF) n_stretch = r_stretch + 8'd1;
                                n_phase = P_RX_STRETCH; n_delay = us_ticks(3'd1);
                            end
                        end
                        P_RX_HOLD: begin
                            v_sh = {r_shift[6:0], i_item.sda};
                            n_shift = v_sh;
                            n_bits = r_bits + 4'd1;
                            n_scl = 1'b0;
                            if (r_bits < 4'd7) begin
                                n_phase = P_RX_LOW; n_delay = us_ticks(3'd4);
                            end else begin
                                n_sda = 1'b0;
                                n_res.rx_valid = 1'b1;
                                n_res.rx_byte = v_sh;
                                n_res.rx_kind = r_stage;
                                v_left = (r_left != 16'd0) ? r_left - 16'd1 : r_left;
                                n_left = v_left;
                                if (r_stage == KIND_LEN) begin
                                    v_flen = {r_flen[7:0], v_sh};
                                    n_flen = v_flen;
                                    v_pay = (v_flen >= 16'd2) ? v_flen - 16'd2 : 16'd0;
                                    if (v_left == 16'd0) begin
                                        if (v_pay != 16'd0) begin
                                            n_stage = KIND_PAY; n_left = v_pay;
                                        end else begin
                                            n_stage = KIND_STATUS; n_left = 16'd2;
                                        end
                                    end
                                end else if (r_stage == KIND_PAY) begin
                                    if (v_left == 16'd0) begin
                                        n_stage = KIND_STATUS; n_left = 16'd2;
                                    end
                                end else begin
                                    v_last = (v_left == 16'd0);
                                end
                                n_res.rx_last = v_last;
                                if (v_last) begin
                                    n_sda = 1'b1; n_phase = P_NK_A; n_delay = us_ticks(3'd3);
                                end else begin
                                    n_phase = P_AK_A; n_delay = us_ticks(3'd4);
                                end
                            end
                        end
                        P_AK_A: begin
                            n_scl = 1'b1; n_phase = P_AK_B; n_delay = us_ticks(3'd4);
                        end
                        P_AK_B: begin
                            n_sda = 1'b1; n_shift = '0; n_bits = '0; n_stretch = '0;
                            n_scl = 1'b0; n_phase = P_RX_LOW; n_delay = us_ticks(3'd4);
                        end
                        P_NK_A: begin
                            n_scl = 1'b1; n_phase = P_NK_B; n_delay = us_ticks(3'd4);
                        end
                        P_NK_B: begin
                            n_est = ST_OK; n_scl = 1'b0;
                            n_phase = P_SP_A; n_delay = us_ticks(3'd1);
                        end
                        default: begin
                            n_phase = P_IDLE; n_res.done = 1'b1; n_res.status = ST_OK;
                        end
                    endcase
                end
            end
        end else if (r_phase == P_IDLE && i_item.op == OP_WRITE) begin
            n_rd = 1'b0; n_hbyte = i_item.tx_byte; n_hlast = i_item.last;
            if (i_item.first) begin
                n_addr = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                n_phase = P_START_A; n_delay = us_ticks(3'd2);
            end else begin
                n_addr = 1'b0; n_phase = P_WR_GAP; n_delay = us_ticks(3'd1);
            end
        end else if (r_phase == P_IDLE && i_item.op == OP_READ) begin
            n_rd = 1'b1; n_addr = 1'b1; n_retry = '0; n_flen = '0;
            n_sda = 1'b1; n_scl = 1'b1;
            n_phase = P_START_A; n_delay = us_ticks(3'd2);
        end
        n_res.scl = n_scl;
        n_res.sda = n_sda;
        n_res.busy = (n_phase != P_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE; r_delay <= '0; r_bits <= '0; r_shift <= '0;
            r_retry <= '0; r_stretch <= '0; r_flen <= '0; r_left <= '0;
            r_scl <= 1'b1; r_sda <= 1'b1; r_rd <= 1'b0; r_addr <= 1'b0;
            r_hlast <= 1'b0; r_hbyte <= '0; r_est <= ST_OK; r_stage <= KIND_LEN;
        end else if (i_step) begin
            r_phase <= n_phase; r_delay <= n_delay; r_bits <= n_bits;
            r_shift <= n_shift; r_retry <= n_retry; r_stretch <= n_stretch;
            r_flen <= n_flen; r_left <= n_left; r_scl <= n_scl; r_sda <= n_sda;
            r_rd <= n_rd; r_addr <= n_addr; r_hlast <= n_hlast; r_hbyte <= n_hbyte;
            r_est <= n_est; r_stage <= n_stage;
        end
    end

    assign o_res = n_res;
endmodule

// File: sv/i2c_framed_master_core.sv
// I2C framed master core: top level with input register and result register
// Path from input transfer to result: input register, then result register.
// Throughput: one item per cycle while the skid entry is empty; the skid entry holds
// one result while the result side is stalled, and tready is low while it is full.
// Bus timing is set by tick items; one step of the sequencer per tick.
// Reset (synchronous, active low): idle, SCL and SDA released high, registers defaulted.
module i2c_framed_master_core
    import ifm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tx_byte[7:0], frame_first[8], sda_level[9], scl_level[10], zero fill [15:11]
    input  logic [15:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    // frame_last
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_drive[0], sda_drive[1], busy_res[2], rx_valid[3], rx_byte[11:4],
    // done_res[12], status[14:13], zero fill [15]
    output logic [15:0] m_axis_tdata,
    // rx_kind[1:0]
    output logic [1:0]  m_axis_tuser,
    // rx_last
    output logic        m_axis_tlast
);
    `include "i2c_framed_master_core_assert.svh"

    t_cfg    w_cfg;
    t_result w_res;
    t_item   r_item;
    logic    r_in_vld;
    t_result r_out, r_skid;
    logic    r_out_vld, r_skid_vld;
    logic    w_step;

    ifm_cfg_regs u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .o_cfg(w_cfg)
    );

    // stage the registered item into the sequencer when the result can be held
    assign w_step = r_in_vld && !r_skid_vld;
    assign s_axis_tready = !r_skid_vld;

    ifm_engine u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(w_cfg),
        .i_step(w_step), .i_item(r_item), .o_res(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.op      <= s_axis_tuser;
            r_item.tx_byte <= s_axis_tdata[7:0];
            r_item.first   <= s_axis_tdata[8];
            r_item.last    <= s_axis_tlast;
            r_item.sda     <= s_axis_tdata[9];
            r_item.scl     <= s_axis_tdata[10];
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (!r_out_vld || m_axis_tready) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= w_step;
                end
            end else if (w_step) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || m_axis_tready) begin
            r_out <= r_skid_vld ? r_skid : w_res;
        end else if (w_step) begin
            r_skid <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tlast  = r_out.rx_last;
    assign m_axis_tuser  = r_out.rx_kind;
    assign m_axis_tdata  = {1'b0, r_out.status, r_out.done,
                            r_out.rx_byte, r_out.rx_valid, r_out.busy,
                            r_out.sda, r_out.scl};

    `IFM_ASSERT_IMP(a_skid_only_when_full, i_clk, i_rst_n, r_skid_vld, r_out_vld)
    `IFM_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `IFM_ASSERT_IMP(a_no_step_on_skid, i_clk, i_rst_n, r_skid_vld, !w_step)
endmodule
